FILE: src/sptc_pkg.sv
// Shared widths, payload types and helper types of the same-pressure temperature conflict check.
`default_nettype none

package sptc_pkg;

    localparam int LVL_W  = 10;
    localparam int PRES_W = 21;
    localparam int TEMP_W = 16;
    localparam int FIN_W  = 18;
    localparam int DIFF_W = 19;
    localparam int DIST_W = 17;
    localparam int CNT_W  = 10;
    localparam int CNT_MAX = 1023;
    localparam int MAX_RES = 3;
    localparam int RCNT_W = 2;

    // Level held in the input register, with its corrected temperature
    // and its distance from background already worked out.
    typedef struct packed {
        logic                     valid;
        logic [LVL_W-1:0]         level_index;
        logic [PRES_W-1:0]        pressure;
        logic signed [FIN_W-1:0]  final_temp;
        logic [DIST_W-1:0]        bkg_dist;
        logic                     obs_missing;
        logic                     end_of_profile;
    } stage_t;

    typedef struct packed {
        logic [LVL_W-1:0] flag_level;
        logic             set_reject;
        logic             set_interp;
        logic             summary_item;
        logic             profile_failed;
        logic [CNT_W-1:0] conflict_count;
        logic             last_result;
    } result_t;

    typedef struct packed {
        logic [RCNT_W-1:0]         count;
        result_t [MAX_RES-1:0]     res;
    } eval_t;

endpackage

`default_nettype wire

FILE: src/sptc_if.sv
// Handshake interfaces for the level input channel and the result output channel.
`default_nettype none

interface sptc_level_if;
    import sptc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [LVL_W-1:0]         level_index;
    logic [PRES_W-1:0]        pressure;
    logic [TEMP_W-1:0]        obs_temp;
    logic signed [TEMP_W-1:0] temp_correction;
    logic [TEMP_W-1:0]        bkg_temp;
    logic                     obs_missing;
    logic                     end_of_profile;

    modport source (
        output valid, level_index, pressure, obs_temp, temp_correction, bkg_temp,
               obs_missing, end_of_profile,
        input  ready
    );

    modport sink (
        input  valid, level_index, pressure, obs_temp, temp_correction, bkg_temp,
               obs_missing, end_of_profile,
        output ready
    );
endinterface

interface sptc_result_if;
    import sptc_pkg::*;

    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] flag_level;
    logic             set_reject;
    logic             set_interp;
    logic             summary_item;
    logic             profile_failed;
    logic [CNT_W-1:0] conflict_count;
    logic             last_result;

    modport source (
        output valid, flag_level, set_reject, set_interp, summary_item, profile_failed,
               conflict_count, last_result,
        input  ready
    );

    modport sink (
        input  valid, flag_level, set_reject, set_interp, summary_item, profile_failed,
               conflict_count, last_result,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/same_pressure_temp_conflict_check.sv
// Top level of the same-pressure temperature conflict check.
//
// Usage: profile levels arrive on the levels channel, one transfer per level,
// in profile order. Each level is first captured in an input register, where
// its corrected temperature and its distance from background are formed. In
// the next stage it is compared against the single held reference level, and
// its results (none, two flag results, a summary, or flags then summary) are
// loaded into a three-entry result buffer that feeds the results channel.
// Each level goes through the input register and then the result buffer.
// While results.ready is high, a level that causes at most one result is
// taken every cycle; one that causes two or three holds the following level
// until its last result goes out, as the buffer empties one result a cycle.
// The temp_threshold register is written through cfg_wr_en and cfg_wr_data
// and should only change while no level is in flight.
// Reset clears the threshold, the reference level, the conflict tally and
// both pipeline stages. When the receiver stalls, results wait in the
// buffer, the input register keeps its level, and levels.ready drops.
`default_nettype none

module same_pressure_temp_conflict_check #(
    parameter int MAX_LEVELS = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    sptc_level_if.sink                        levels,
    sptc_result_if.source                     results,
    input  wire logic                         cfg_wr_en,
    input  wire logic [sptc_pkg::TEMP_W-1:0]  cfg_wr_data
);
    import sptc_pkg::*;

    stage_t stg;
    eval_t  ev;
    logic   free;
    logic   advance;

    // A held level moves on once the buffer can take all of its results.
    assign advance = stg.valid && free;

    sptc_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .levels  (levels),
        .advance (advance),
        .stg     (stg)
    );

    sptc_eval #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stg         (stg),
        .advance     (advance),
        .ev          (ev)
    );

    sptc_out_buf u_out_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .ev      (ev),
        .load    (advance),
        .free    (free),
        .results (results)
    );

    // A summary is always the final result of its level.
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.summary_item |-> results.last_result)
        else $error("summary result without last_result");

    // A flag result marks its level with exactly one of reject or interpolate.
    a_flag_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.summary_item |-> results.set_reject != results.set_interp)
        else $error("flag result with both or neither mark");

    // Input backpressure only happens while a level is held and cannot move on.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !levels.ready |-> stg.valid && !free)
        else $error("levels.ready low without a blocked level");

    // A summary transfer never carries flag marks.
    a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.summary_item |-> !results.set_reject && !results.set_interp)
        else $error("summary result carries flag marks");
endmodule

`default_nettype wire

FILE: src/sptc_in_stage.sv
// Input register that also forms the corrected temperature and background distance.
`default_nettype none

module sptc_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    sptc_level_if.sink           levels,
    input  wire logic            advance,
    output sptc_pkg::stage_t     stg
);
    import sptc_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    stage_t                   data_reg;
    stage_t                   data_next;
    logic                     take;
    logic signed [FIN_W-1:0]  fin;
    logic signed [FIN_W-1:0]  bdiff;
    logic [FIN_W-1:0]         bdiff_abs;

    assign levels.ready = !valid_reg || advance;
    assign take         = levels.valid && levels.ready;

    always_comb
    begin
        fin = $signed({2'b00, levels.obs_temp})
            + $signed({{(FIN_W-TEMP_W){levels.temp_correction[TEMP_W-1]}},
                       levels.temp_correction});
        bdiff     = fin - $signed({2'b00, levels.bkg_temp});
        bdiff_abs = bdiff[FIN_W-1] ? FIN_W'(-bdiff) : FIN_W'(bdiff);

        data_next                = data_reg;
        data_next.valid          = 1'b1;
        data_next.level_index    = levels.level_index;
        data_next.pressure       = levels.pressure;
        data_next.final_temp     = fin;
        data_next.bkg_dist       = bdiff_abs[DIST_W-1:0];
        data_next.obs_missing    = levels.obs_missing;
        data_next.end_of_profile = levels.end_of_profile;

        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        stg       = data_reg;
        stg.valid = valid_reg;
    end
endmodule

`default_nettype wire

FILE: src/sptc_eval.sv
// Reference level state, threshold register and per-level conflict evaluation.
`default_nettype none

module sptc_eval #(
    parameter int MAX_LEVELS = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [sptc_pkg::TEMP_W-1:0]  cfg_wr_data,
    input  wire sptc_pkg::stage_t             stg,
    input  wire logic                         advance,
    output sptc_pkg::eval_t                   ev
);
    import sptc_pkg::*;

    localparam int TallyCapInt = (MAX_LEVELS - 1 < CNT_MAX) ? MAX_LEVELS - 1 : CNT_MAX;
    localparam logic [CNT_W-1:0] TALLY_CAP = CNT_W'(TallyCapInt);

    logic [TEMP_W-1:0]        thr_reg;
    logic                     ref_valid_reg, ref_valid_next;
    logic [LVL_W-1:0]         ref_index_reg, ref_index_next;
    logic [PRES_W-1:0]        ref_pressure_reg, ref_pressure_next;
    logic signed [FIN_W-1:0]  ref_final_reg, ref_final_next;
    logic [DIST_W-1:0]        ref_dist_reg, ref_dist_next;
    logic [CNT_W-1:0]         tally_reg, tally_next;

    logic                     present;
    logic                     same;
    logic signed [DIFF_W-1:0] tdiff;
    logic [DIFF_W-1:0]        tdiff_abs;
    logic                     conflict;
    logic                     keep_cur;
    logic                     take;
    logic [CNT_W-1:0]         tally_upd;
    result_t                  flag_ref;
    result_t                  flag_cur;
    result_t                  summ;

    always_comb
    begin
        present   = !stg.obs_missing;
        same      = ref_valid_reg && (stg.pressure == ref_pressure_reg);
        tdiff     = {stg.final_temp[FIN_W-1], stg.final_temp}
                  - {ref_final_reg[FIN_W-1], ref_final_reg};
        tdiff_abs = tdiff[DIFF_W-1] ? DIFF_W'(-tdiff) : DIFF_W'(tdiff);
        conflict  = present && same
                  && (tdiff_abs[DIST_W-1:0] > {{(DIST_W-TEMP_W){1'b0}}, thr_reg});
        // On a tie the current level is the one that stays.
        keep_cur  = stg.bkg_dist <= ref_dist_reg;
        take      = present && (!same || (conflict && keep_cur));
        tally_upd = (conflict && (tally_reg < TALLY_CAP)) ? tally_reg + 1'b1 : tally_reg;

        flag_ref                = '0;
        flag_ref.flag_level     = ref_index_reg;
        flag_ref.set_reject     = keep_cur;
        flag_ref.set_interp     = !keep_cur;

        flag_cur                = '0;
        flag_cur.flag_level     = stg.level_index;
        flag_cur.set_reject     = !keep_cur;
        flag_cur.set_interp     = keep_cur;
        flag_cur.last_result    = !stg.end_of_profile;

        summ                    = '0;
        summ.summary_item       = 1'b1;
        summ.profile_failed     = tally_upd != '0;
        summ.conflict_count     = tally_upd;
        summ.last_result        = 1'b1;

        ev.count  = {conflict, 1'b0} + {1'b0, stg.end_of_profile};
        ev.res[2] = summ;
        if (conflict)
        begin
            ev.res[0] = flag_ref;
            ev.res[1] = flag_cur;
        end
        else
        begin
            ev.res[0] = summ;
            ev.res[1] = '0;
        end

        ref_valid_next    = ref_valid_reg;
        ref_index_next    = ref_index_reg;
        ref_pressure_next = ref_pressure_reg;
        ref_final_next    = ref_final_reg;
        ref_dist_next     = ref_dist_reg;
        tally_next        = tally_upd;
        if (stg.end_of_profile)
        begin
            // The summary closes the profile; the next level starts afresh.
            ref_valid_next    = 1'b0;
            ref_index_next    = '0;
            ref_pressure_next = '0;
            ref_final_next    = '0;
            ref_dist_next     = '0;
            tally_next        = '0;
        end
        else if (take)
        begin
            ref_valid_next    = 1'b1;
            ref_index_next    = stg.level_index;
            ref_pressure_next = stg.pressure;
            ref_final_next    = stg.final_temp;
            ref_dist_next     = stg.bkg_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg          <= '0;
            ref_valid_reg    <= 1'b0;
            ref_index_reg    <= '0;
            ref_pressure_reg <= '0;
            ref_final_reg    <= '0;
            ref_dist_reg     <= '0;
            tally_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                ref_valid_reg    <= ref_valid_next;
                ref_index_reg    <= ref_index_next;
                ref_pressure_reg <= ref_pressure_next;
                ref_final_reg    <= ref_final_next;
                ref_dist_reg     <= ref_dist_next;
                tally_reg        <= tally_next;
            end
        end
    end
endmodule

`default_nettype wire

FILE: src/sptc_out_buf.sv
// Three-entry result buffer that drains one result per transfer.
`default_nettype none

module sptc_out_buf (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sptc_pkg::eval_t ev,
    input  wire logic            load,
    output logic                 free,
    sptc_result_if.source        results
);
    import sptc_pkg::*;

    result_t [MAX_RES-1:0] slot_reg;
    result_t [MAX_RES-1:0] slot_next;
    logic [RCNT_W-1:0]     cnt_reg;
    logic [RCNT_W-1:0]     cnt_next;
    logic                  pop;

    assign results.valid = cnt_reg != '0;
    assign pop           = results.valid && results.ready;
    assign free          = (cnt_reg == '0) || ((cnt_reg == RCNT_W'(1)) && results.ready);

    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            slot_next = ev.res;
            cnt_next  = ev.count;
        end
        else if (pop)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign results.flag_level     = slot_reg[0].flag_level;
    assign results.set_reject     = slot_reg[0].set_reject;
    assign results.set_interp     = slot_reg[0].set_interp;
    assign results.summary_item   = slot_reg[0].summary_item;
    assign results.profile_failed = slot_reg[0].profile_failed;
    assign results.conflict_count = slot_reg[0].conflict_count;
    assign results.last_result    = slot_reg[0].last_result;
endmodule

`default_nettype wire

FILE: sim/tb_same_pressure_temp_conflict_check.sv
// Self-checking testbench for the same-pressure temperature conflict check.
`default_nettype none

module tb_same_pressure_temp_conflict_check;
    timeunit 1ns;
    timeprecision 1ps;

    import sptc_pkg::*;

    // The block is built with its default profile depth, so the conflict
    // tally stops at the smaller of the counter ceiling and one less than
    // the depth.
    localparam int MAX_LEVELS     = 1024;
    localparam int TALLY_CAP      = (MAX_LEVELS - 1 < CNT_MAX) ? MAX_LEVELS - 1 : CNT_MAX;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 50;
    localparam int RANDOM_LEVELS  = 85;
    localparam int SAT_LEVELS     = 40;

    // One level as the sender hands it over.
    typedef struct packed {
        logic [LVL_W-1:0]         level_index;
        logic [PRES_W-1:0]        pressure;
        logic [TEMP_W-1:0]        obs_temp;
        logic signed [TEMP_W-1:0] temp_correction;
        logic [TEMP_W-1:0]        bkg_temp;
        logic                     obs_missing;
        logic                     end_of_profile;
    } level_item_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [TEMP_W-1:0] cfg_wr_data;

    sptc_level_if  lvl_ch ();
    sptc_result_if res_ch ();

    same_pressure_temp_conflict_check #(
        .MAX_LEVELS (MAX_LEVELS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .levels      (lvl_ch),
        .results     (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Levels waiting to be offered, and the flag and summary results that
    // the accepted levels are known to cause, oldest first.
    level_item_t pending_levels[$];
    result_t     expected_results[$];
    level_item_t on_bus;

    // Our own copy of the block's state: the threshold register, the held
    // reference level and the conflict tally of the open profile.
    logic [TEMP_W-1:0] temp_thr;
    bit                ref_held;
    logic [LVL_W-1:0]  ref_lvl;
    logic [PRES_W-1:0] ref_pres;
    int                ref_fin;
    int                ref_bkg;
    int                tally;

    // Idling percentages of the current phase.
    int send_idle_pct;
    int recv_stall_pct;

    int error_count;
    int levels_sent;
    int results_checked;
    int conflicts_seen;
    int summaries_seen;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic int abs_int(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clamp_temp(input int v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    function automatic result_t flag_result(input logic [LVL_W-1:0] lvl, input logic rej,
                                            input logic itp);
        result_t r;
        r = '0;
        r.flag_level = lvl;
        r.set_reject = rej;
        r.set_interp = itp;
        return r;
    endfunction

    function automatic level_item_t make_level(input int idx, input int pres, input int obs,
                                               input int corr, input int bkg,
                                               input bit miss, input bit eop);
        level_item_t it;
        it.level_index     = LVL_W'(idx);
        it.pressure        = PRES_W'(pres);
        it.obs_temp        = TEMP_W'(obs);
        it.temp_correction = TEMP_W'(corr);
        it.bkg_temp        = TEMP_W'(bkg);
        it.obs_missing     = miss;
        it.end_of_profile  = eop;
        return it;
    endfunction

    // Works out the results of one accepted level and appends them to the
    // expectation queue. A conflict gives a flag for the reference level
    // and then one for the current level; the end of a profile adds the
    // summary after them. The last one of the batch carries last_result.
    task automatic forecast_flags(input level_item_t it);
        int      fin;
        int      d_cur;
        int      d_ref;
        bit      keep;
        result_t batch[$];
        result_t summ;

        fin = int'(it.obs_temp) + int'($signed(it.temp_correction));
        if (!it.obs_missing)
        begin
            keep = 1'b1;
            if (ref_held && it.pressure == ref_pres)
            begin
                keep = 1'b0;
                if (abs_int(fin - ref_fin) > int'(temp_thr))
                begin
                    conflicts_seen++;
                    if (tally < TALLY_CAP)
                        tally++;
                    d_cur = abs_int(fin - int'(it.bkg_temp));
                    d_ref = abs_int(ref_fin - ref_bkg);
                    // The level closer to its background survives; on a tie
                    // the current level wins and becomes the reference.
                    if (d_cur <= d_ref)
                    begin
                        batch.push_back(flag_result(ref_lvl, 1'b1, 1'b0));
                        batch.push_back(flag_result(it.level_index, 1'b0, 1'b1));
                        keep = 1'b1;
                    end
                    else
                    begin
                        batch.push_back(flag_result(ref_lvl, 1'b0, 1'b1));
                        batch.push_back(flag_result(it.level_index, 1'b1, 1'b0));
                    end
                end
            end
            if (keep)
            begin
                ref_held = 1'b1;
                ref_lvl  = it.level_index;
                ref_pres = it.pressure;
                ref_fin  = fin;
                ref_bkg  = int'(it.bkg_temp);
            end
        end

        if (it.end_of_profile)
        begin
            summ                = '0;
            summ.summary_item   = 1'b1;
            summ.profile_failed = (tally > 0);
            summ.conflict_count = CNT_W'(tally);
            batch.push_back(summ);
            summaries_seen++;
            ref_held = 1'b0;
            ref_lvl  = '0;
            ref_pres = '0;
            ref_fin  = 0;
            ref_bkg  = 0;
            tally    = 0;
        end

        if (batch.size() > 0)
            batch[batch.size() - 1].last_result = 1'b1;
        foreach (batch[i])
            expected_results.push_back(batch[i]);
    endtask

    // Sender. An offered level stays on the channel until it is taken; a new
    // one, or a gap, is only chosen once the channel is free again.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            lvl_ch.valid <= 1'b0;
        end
        else
        begin
            if (lvl_ch.valid && lvl_ch.ready)
            begin
                forecast_flags(on_bus);
                levels_sent++;
            end
            if (!lvl_ch.valid || lvl_ch.ready)
            begin
                if (pending_levels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    on_bus = pending_levels.pop_front();
                    lvl_ch.valid           <= 1'b1;
                    lvl_ch.level_index     <= on_bus.level_index;
                    lvl_ch.pressure        <= on_bus.pressure;
                    lvl_ch.obs_temp        <= on_bus.obs_temp;
                    lvl_ch.temp_correction <= on_bus.temp_correction;
                    lvl_ch.bkg_temp        <= on_bus.bkg_temp;
                    lvl_ch.obs_missing     <= on_bus.obs_missing;
                    lvl_ch.end_of_profile  <= on_bus.end_of_profile;
                end
                else
                begin
                    lvl_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every result transfer is checked field by field against the
    // oldest expectation; ready is redrawn each cycle for the stall pattern.
    always @(posedge clk)
    begin : result_monitor
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                seen.flag_level     = res_ch.flag_level;
                seen.set_reject     = res_ch.set_reject;
                seen.set_interp     = res_ch.set_interp;
                seen.summary_item   = res_ch.summary_item;
                seen.profile_failed = res_ch.profile_failed;
                seen.conflict_count = res_ch.conflict_count;
                seen.last_result    = res_ch.last_result;
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with none pending, flag_level",
                                    seen.flag_level, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen.flag_level !== want.flag_level)
                        report_mismatch("flag_level", seen.flag_level, want.flag_level);
                    if (seen.set_reject !== want.set_reject)
                        report_mismatch("set_reject", seen.set_reject, want.set_reject);
                    if (seen.set_interp !== want.set_interp)
                        report_mismatch("set_interp", seen.set_interp, want.set_interp);
                    if (seen.summary_item !== want.summary_item)
                        report_mismatch("summary_item", seen.summary_item, want.summary_item);
                    if (seen.profile_failed !== want.profile_failed)
                        report_mismatch("profile_failed", seen.profile_failed,
                                        want.profile_failed);
                    if (seen.conflict_count !== want.conflict_count)
                        report_mismatch("conflict_count", seen.conflict_count,
                                        want.conflict_count);
                    if (seen.last_result !== want.last_result)
                        report_mismatch("last_result", seen.last_result, want.last_result);
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: a long stretch with no transfer on either channel means the
    // block has hung, so the run is ended as a failure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((lvl_ch.valid && lvl_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_same_pressure_temp_conflict_check: done, errors");
                $finish;
            end
        end
    end

    // The threshold is only written while nothing is in flight. The task
    // returns on a falling edge so that the caller can touch the queues and
    // the idling settings without racing the clocked processes.
    task automatic start_phase(input int send_pct, input int recv_pct,
                               input logic [TEMP_W-1:0] thr);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        temp_thr     = thr;
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Waits until every level has been taken and every expected result has
    // come back, then waits out a drain period for a level that caused nothing.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_levels.size() != 0 || lvl_ch.valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Queues one random profile. Most levels share three pressures so that
    // same-pressure comparisons happen often, with temperatures spread about a
    // base by a range set from the threshold so conflicts and near misses both
    // occur. A share of fully random levels covers every bit of every field.
    task automatic queue_random_profile(inout int budget);
        int          n;
        int          spread;
        int          base_temp;
        int          idx0;
        int          obs;
        int          pool[3];
        level_item_t it;

        n         = $urandom_range(1, 12);
        base_temp = $urandom_range(0, 65535);
        idx0      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : 0;
        spread    = int'(temp_thr) * 2 + 200;
        if (spread > 30000)
            spread = 30000;
        foreach (pool[k])
            pool[k] = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 2097151);

        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                it = make_level($urandom_range(0, 1023), $urandom_range(0, 2097151),
                                $urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 65535), $urandom_range(0, 1),
                                ($urandom_range(0, 7) == 0) || (i == n - 1));
            end
            else
            begin
                obs = clamp_temp(base_temp + $urandom_range(0, 2 * spread) - spread);
                it = make_level(idx0 + i, pool[$urandom_range(0, 2)], obs,
                                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 1000) - 500,
                                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                            : clamp_temp(obs + $urandom_range(0, 2000) - 1000),
                                ($urandom_range(0, 9) == 0), (i == n - 1));
            end
            pending_levels.push_back(it);
            if (!it.obs_missing)
                budget--;
        end
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct,
                                    input logic [TEMP_W-1:0] thr);
        int budget;
        start_phase(send_pct, recv_pct, thr);
        budget = RANDOM_LEVELS;
        while (budget > 0)
            queue_random_profile(budget);
        wait_idle();
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        lvl_ch.valid           = 1'b0;
        lvl_ch.level_index     = '0;
        lvl_ch.pressure        = '0;
        lvl_ch.obs_temp        = '0;
        lvl_ch.temp_correction = '0;
        lvl_ch.bkg_temp        = '0;
        lvl_ch.obs_missing     = 1'b0;
        lvl_ch.end_of_profile  = 1'b0;
        res_ch.ready           = 1'b0;
        temp_thr               = '0;
        ref_held               = 1'b0;
        ref_lvl                = '0;
        ref_pres               = '0;
        ref_fin                = 0;
        ref_bkg                = 0;
        tally                  = 0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        error_count            = 0;
        levels_sent            = 0;
        results_checked        = 0;
        conflicts_seen         = 0;
        summaries_seen         = 0;
        quiet_cycles           = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with a zero threshold: any difference at all is a
        // conflict. The first profile starts at the top pressure with the
        // hottest and coldest corrected temperatures, so the current level
        // is farther from background and is rejected. It then skips a missing
        // level, sees an equal temperature that is no conflict, moves to a
        // new pressure, hits a distance tie that keeps the current level,
        // and closes on a missing final level that still gives a summary.
        start_phase(0, 0, 16'd0);
        pending_levels.push_back(make_level(0, 2097151, 65535, 32767, 65535, 0, 0));
        pending_levels.push_back(make_level(1, 2097151, 0, -32768, 0, 0, 0));
        pending_levels.push_back(make_level(2, 2097151, 12345, 0, 0, 1, 0));
        pending_levels.push_back(make_level(3, 2097151, 65535, 32767, 0, 0, 0));
        pending_levels.push_back(make_level(4, 0, 30000, 0, 30000, 0, 0));
        pending_levels.push_back(make_level(5, 0, 30010, 0, 30010, 0, 0));
        pending_levels.push_back(make_level(6, 0, 0, 0, 0, 1, 1));
        // A one-level profile at zero pressure: the cleared reference must
        // not be mistaken for a held one, so the summary shows no conflict.
        pending_levels.push_back(make_level(1023, 0, 29315, 0, 29000, 0, 1));
        // A conflict on the final level gives two flags and the summary.
        pending_levels.push_back(make_level(0, 1000, 25000, -100, 25000, 0, 0));
        pending_levels.push_back(make_level(1, 1000, 25000, 100, 25050, 0, 1));
        // A missing first level is skipped and the next one is the reference.
        pending_levels.push_back(make_level(0, 7, 0, 0, 0, 1, 0));
        pending_levels.push_back(make_level(1, 7, 20000, 0, 20500, 0, 0));
        pending_levels.push_back(make_level(2, 7, 20001, 0, 20000, 0, 0));
        pending_levels.push_back(make_level(3, 8, 20000, 0, 0, 0, 1));
        wait_idle();

        // Largest threshold: a difference of exactly the threshold passes,
        // one more is a conflict, and the widest corrected spread exceeds it.
        start_phase(0, 0, 16'hFFFF);
        pending_levels.push_back(make_level(0, 5, 0, 0, 0, 0, 0));
        pending_levels.push_back(make_level(1, 5, 65535, 0, 0, 0, 0));
        pending_levels.push_back(make_level(2, 5, 65535, 1, 0, 0, 0));
        pending_levels.push_back(make_level(1023, 5, 65535, 32767, 65535, 0, 1));
        wait_idle();

        // Random profiles under each idling pattern and several thresholds.
        run_random_phase(0, 0, 16'd100);
        run_random_phase(76, 0, 16'($urandom_range(300, 5000)));
        run_random_phase(0, 76, 16'd0);
        run_random_phase(23, 23, 16'd2000);

        // One long profile at a single pressure with every corrected
        // temperature distinct, so each level after the first conflicts and
        // the tally climbs far beyond what the short profiles reach.
        start_phase(0, 0, 16'd0);
        begin : saturation_profile
            int sat_pres;
            sat_pres = $urandom_range(0, 2097151);
            for (int i = 0; i < SAT_LEVELS; i++)
                pending_levels.push_back(make_level(i, sat_pres, 10000 + 40 * i, 0,
                                                    $urandom_range(0, 65535), 0,
                                                    (i == SAT_LEVELS - 1)));
        end
        wait_idle();

        while (expected_results.size() != 0)
        begin
            report_mismatch("result never delivered, flag_level",
                            -1, expected_results[0].flag_level);
            void'(expected_results.pop_front());
        end

        $display("Sent %0d levels, checked %0d results: %0d conflicts over %0d profiles.",
                 levels_sent, results_checked, conflicts_seen, summaries_seen);
        $display("Thresholds from 0 to 65535, four idling patterns, one long all-conflict profile.");
        if (error_count == 0)
            $display("tb_same_pressure_temp_conflict_check: done, clean");
        else
            $display("tb_same_pressure_temp_conflict_check: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
